// ===== sv/odbp_pkg.sv =====
// ----------------------------------------------------------------------------
// odbp_pkg : shared types and constants for the ordered-dither plane packer
// Colour cube split, dither pattern table and per-pixel plane bit types.
// ----------------------------------------------------------------------------
package odbp_pkg;

  localparam int unsigned IndexWidth = 7;
  localparam int unsigned PlaneWidth = 8;
  localparam int unsigned LevelWidth = 3;
  localparam int unsigned PosWidth   = 3;
  localparam int unsigned NumLevels  = 5;

  localparam logic [IndexWidth-1:0] CubeMax = 7'd124;
  localparam logic [IndexWidth-1:0] RedStep = 7'd25;
  localparam logic [IndexWidth-1:0] LvlStep = 7'd5;

  typedef logic [LevelWidth-1:0] level_t;
  typedef logic [PlaneWidth-1:0] plane_t;
  typedef logic [PosWidth-1:0]   bitpos_t;

  typedef struct packed {
    level_t red;
    level_t green;
    level_t blue;
  } levels_t;

  typedef struct packed {
    plane_t red;
    plane_t green;
    plane_t blue;
  } plane_bits_t;

  // Dither bytes, one row per y parity, indexed by level 0..4.
  localparam plane_t Pattern [2][NumLevels] = '{
    '{8'd0, 8'd34,  8'd102, 8'd221, 8'd255},
    '{8'd0, 8'd136, 8'd153, 8'd119, 8'd255}
  };

  // Quotient of a value below 5*step by a constant step, via compare chain.
  function automatic level_t div_small(logic [IndexWidth-1:0] v,
                                       logic [IndexWidth-1:0] step);
    level_t q;
    q = 3'd0;
    if (v >= IndexWidth'(step * 7'd4))      q = 3'd4;
    else if (v >= IndexWidth'(step * 7'd3)) q = 3'd3;
    else if (v >= IndexWidth'(step * 7'd2)) q = 3'd2;
    else if (v >= step)                     q = 3'd1;
    return q;
  endfunction

  // Split a cube index into red/green/blue levels; out-of-range clamps to white.
  function automatic levels_t cube_split(logic [IndexWidth-1:0] c);
    logic [IndexWidth-1:0] cc;
    logic [IndexWidth-1:0] rem;
    levels_t               lv;
    cc       = (c > CubeMax) ? CubeMax : c;
    lv.red   = div_small(cc, RedStep);
    rem      = cc - IndexWidth'({4'b0, lv.red} * RedStep);
    lv.green = div_small(rem, LvlStep);
    rem      = rem - IndexWidth'({4'b0, lv.green} * LvlStep);
    lv.blue  = rem[LevelWidth-1:0];
    return lv;
  endfunction

  // Mask of the pixel's bit within a plane byte, MSB first.
  function automatic plane_t pos_mask(bitpos_t pos);
    return plane_t'(8'h80 >> pos);
  endfunction

endpackage

// ===== sv/ordered_dither_bitplane_packer.sv =====
// ----------------------------------------------------------------------------
// ordered_dither_bitplane_packer : ordered-dither colour cube to bitplanes
// Packs dithered pixels of a 5x5x5 colour cube into red, green and blue
// plane bytes, emitting one byte triple per eight pixels or at row end.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  in      | in_valid/in_ready  | color_index, pixel_x, pixel_y, row_end
//  out     | out_valid/out_ready| red_plane, green_plane, blue_plane
//
//  One request per clock, sustained unless a flush waits on a stalled result;
//  a pixel reaches the input register, then decode/OR into the result register.
//  The accumulators are the only loop.
//  Reset clears the stage valids and the accumulators.
//  A stalled result holds only pixels that flush; other pixels keep flowing.
// ----------------------------------------------------------------------------
module ordered_dither_bitplane_packer #(
  parameter int unsigned COORD_WIDTH = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [odbp_pkg::IndexWidth-1:0] in_color_index,
  input  logic [COORD_WIDTH-1:0]          in_pixel_x,
  input  logic [COORD_WIDTH-1:0]          in_pixel_y,
  input  logic                            in_row_end,
  output logic                            out_valid,
  input  logic                            out_ready,
  output odbp_pkg::plane_t                out_red_plane,
  output odbp_pkg::plane_t                out_green_plane,
  output odbp_pkg::plane_t                out_blue_plane
);
  import odbp_pkg::*;

  // Input register: only the coordinate bits that matter are kept.
  logic                  s1_valid_r;
  logic [IndexWidth-1:0] s1_color_r;
  bitpos_t               s1_pos_r;
  logic                  s1_row_r;
  logic                  s1_last_r;

  // Accumulators and result register.
  plane_t red_acc_r, green_acc_r, blue_acc_r;
  plane_t red_acc_nxt, green_acc_nxt, blue_acc_nxt;
  logic   out_valid_r;
  plane_t out_red_r, out_green_r, out_blue_r;

  plane_bits_t pix_bits;
  plane_t      red_sum, green_sum, blue_sum;
  logic        s1_flush;
  logic        s1_advance;
  logic        in_fire;

  odbp_pixel_bits u_pixel_bits (
    .color_index (s1_color_r),
    .row         (s1_row_r),
    .pos         (s1_pos_r),
    .bits        (pix_bits)
  );

  assign red_sum   = red_acc_r   | pix_bits.red;
  assign green_sum = green_acc_r | pix_bits.green;
  assign blue_sum  = blue_acc_r  | pix_bits.blue;

  // Flush on the last bit of a byte or at row end; a flush needs room out.
  assign s1_flush   = (s1_pos_r == bitpos_t'(7)) || s1_last_r;
  assign s1_advance = s1_valid_r && (!s1_flush || !out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_advance;
  assign in_fire    = in_valid && in_ready;

  always_comb begin
    red_acc_nxt   = red_acc_r;
    green_acc_nxt = green_acc_r;
    blue_acc_nxt  = blue_acc_r;
    if (s1_advance) begin
      red_acc_nxt   = s1_flush ? '0 : red_sum;
      green_acc_nxt = s1_flush ? '0 : green_sum;
      blue_acc_nxt  = s1_flush ? '0 : blue_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      red_acc_r   <= '0;
      green_acc_r <= '0;
      blue_acc_r  <= '0;
    end else begin
      red_acc_r   <= red_acc_nxt;
      green_acc_r <= green_acc_nxt;
      blue_acc_r  <= blue_acc_nxt;
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_advance && s1_flush) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_color_r <= in_color_index;
      s1_pos_r   <= in_pixel_x[PosWidth-1:0];
      s1_row_r   <= in_pixel_y[0];
      s1_last_r  <= in_row_end;
    end
    if (s1_advance && s1_flush) begin
      out_red_r   <= red_sum;
      out_green_r <= green_sum;
      out_blue_r  <= blue_sum;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red_plane   = out_red_r;
  assign out_green_plane = out_green_r;
  assign out_blue_plane  = out_blue_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_advance && s1_flush) |=>
      (red_acc_r == '0 && green_acc_r == '0 && blue_acc_r == '0))
    else $error("accumulators not cleared after flush");

  a_flush_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_flush && out_valid_r && !out_ready) |=>
      (s1_valid_r && $stable(s1_pos_r) && $stable(s1_last_r)))
    else $error("stalled flush pixel lost");

  a_ready_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a blocked result");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_advance && s1_flush) |=> out_valid_r)
    else $error("flush did not produce a result");

endmodule

// ===== sv/odbp_pixel_bits.sv =====
// ----------------------------------------------------------------------------
// odbp_pixel_bits : dithered plane bits for one pixel
// Splits the cube index and picks the pattern bit at the pixel position.
// ----------------------------------------------------------------------------
module odbp_pixel_bits (
  input  logic [odbp_pkg::IndexWidth-1:0] color_index,
  input  logic                            row,
  input  odbp_pkg::bitpos_t               pos,
  output odbp_pkg::plane_bits_t           bits
);
  import odbp_pkg::*;

  levels_t lv;
  plane_t  mask;

  assign lv   = cube_split(color_index);
  assign mask = pos_mask(pos);

  always_comb begin
    bits.red   = Pattern[row][lv.red]   & mask;
    bits.green = Pattern[row][lv.green] & mask;
    bits.blue  = Pattern[row][lv.blue]  & mask;
  end

endmodule
